FILE: hw/rtl/ags_pkg.sv
// ----------------------------------------------------------------------------
// ags_pkg: shared types and constants for the adaptive gain scheduler
// Field widths, register indexes, sequencer states and arithmetic sizes.
// ----------------------------------------------------------------------------
package ags_pkg;

	function automatic int imax(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

	// Field widths
	localparam int RATE_WIDTH     = 16;
	localparam int GAIN_FRAC_BITS = 16;
	localparam int REG_W          = 16;
	localparam int CFG_IDX_W      = 3;

	// Square root: radicand holds three squares, root has RATE_WIDTH bits
	localparam int SUM_W = 2 * RATE_WIDTH;
	localparam int MAG_W = RATE_WIDTH;
	localparam int REM_W = MAG_W + 3;

	// Shared subtractor, multiplier and accumulator sizes
	localparam int SUB_W = imax(REM_W, REG_W + 1);
	localparam int MUL_W = imax(imax(RATE_WIDTH, REG_W), GAIN_FRAC_BITS + 1);
	localparam int PRD_W = 2 * MUL_W;
	localparam int ACC_W = PRD_W + 1;
	localparam int CMP_W = imax(MAG_W, REG_W);

	// Iteration counter
	localparam int ITER_N = imax(MAG_W, REG_W);
	localparam int CNT_W  = $clog2(ITER_N);

	localparam logic [MUL_W-1:0] GAIN_ONE = MUL_W'(1) << GAIN_FRAC_BITS;

	// Register reset values
	localparam logic [REG_W-1:0] RST_LOW_RATE       = REG_W'(320);
	localparam logic [REG_W-1:0] RST_HIGH_RATE      = REG_W'(1600);
	localparam logic [REG_W-1:0] RST_MIN_GAIN       = REG_W'(19661);
	localparam logic [REG_W-1:0] RST_MAX_GAIN       = REG_W'(52429);
	localparam logic [REG_W-1:0] RST_ALPHA_LAUNCHED = REG_W'(19661);
	localparam logic [REG_W-1:0] RST_ALPHA_IDLE     = REG_W'(3277);
	localparam logic [REG_W-1:0] RST_GAIN           = REG_W'(19661);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOW_RATE       = 3'd0,
		REG_HIGH_RATE      = 3'd1,
		REG_MIN_GAIN       = 3'd2,
		REG_MAX_GAIN       = 3'd3,
		REG_ALPHA_LAUNCHED = 3'd4,
		REG_ALPHA_IDLE     = 3'd5
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ,
		ST_SQRT,
		ST_CMP,
		ST_DMUL,
		ST_DIV,
		ST_TGT,
		ST_SM0,
		ST_SM1,
		ST_SM2
	} state_t;

	typedef struct packed {
		logic signed [RATE_WIDTH-1:0] rate_x;
		logic signed [RATE_WIDTH-1:0] rate_y;
		logic signed [RATE_WIDTH-1:0] rate_z;
		logic                         launched;
	} in_item_t;

	typedef struct packed {
		logic [REG_W-1:0] gain;
		logic [REG_W-1:0] rate_magnitude;
	} out_item_t;

	// Result of the shared trial subtraction
	typedef struct packed {
		logic             ge;
		logic [SUB_W-1:0] diff;
	} sub_res_t;

endpackage

FILE: hw/rtl/adaptive_gain_scheduler.sv
// ----------------------------------------------------------------------------
// adaptive_gain_scheduler: gain scheduling from gyro rate magnitude
// Iterative datapath around one multiplier and one trial subtractor.
// ----------------------------------------------------------------------------
// Each gyro transaction takes the floor square root of x^2+y^2+z^2, maps it
// to a target gain (min_gain at or below low_rate, max_gain at or above
// high_rate, truncated linear interpolation between) and moves the stored
// gain towards it by old*(1-a) + target*a in Q0.16, truncated. An item runs
// through the shared multiplier for the squares, 16 one-bit steps of the
// square root and one compare; when the magnitude lies between the thresholds
// it then goes through the product, the 16 one-bit steps of the division and
// the target update, and last through the multiplier steps of the smoothing.
// The sequencer returns to idle before the next transaction. One item is in
// flight at a time; in_ready is high only while the sequencer is idle. The
// result sits in an output register, so the next transaction is taken while
// it waits; a further result then waits in the last smoothing step until the
// output register is free. Configuration writes are taken every cycle
// (cfg_ready is tied high); indexes past the alpha_idle register are ignored.
// ----------------------------------------------------------------------------
module adaptive_gain_scheduler (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  ags_pkg::in_item_t             in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output ags_pkg::out_item_t            out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ags_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ags_pkg::REG_W-1:0]     cfg_data
);

	localparam int RW = ags_pkg::RATE_WIDTH;
	localparam int W  = ags_pkg::REG_W;

	// Configuration registers
	logic [W-1:0] low_rate_q, high_rate_q, min_gain_q, max_gain_q;
	logic [W-1:0] alpha_launched_q, alpha_idle_q;

	// Stored smoothed gain
	logic [W-1:0] gain_q;

	// Sequencer
	ags_pkg::state_t            state_q, state_d;
	logic [ags_pkg::CNT_W-1:0]  cnt_q;
	logic                       cnt_last_sq, cnt_last_root, cnt_last_div;

	// Item working registers
	logic [RW-1:0]               abs_x_q, abs_y_q, abs_z_q;
	logic                        launched_q;
	logic [ags_pkg::SUM_W-1:0]   rad_q;
	logic [ags_pkg::REM_W-1:0]   rem_q;
	logic [ags_pkg::MAG_W-1:0]   root_q;
	logic [2*W-1:0]              nd_q;
	logic [W-1:0]                tgt_q;
	logic [ags_pkg::ACC_W-1:0]   acc_q;

	// Output register
	logic                        out_valid_q;
	ags_pkg::out_item_t          out_q;

	// Shared units
	logic [ags_pkg::MUL_W-1:0]   mul_a, mul_b;
	logic [ags_pkg::PRD_W-1:0]   mul_p;
	logic [ags_pkg::SUB_W-1:0]   sub_a, sub_b;
	ags_pkg::sub_res_t           sub_r;

	// Derived values
	logic [ags_pkg::REM_W-1:0]   root_trial_a, root_trial_b;
	logic [W:0]                  div_trial_a;
	logic [ags_pkg::CMP_W-1:0]   mag_ext, low_ext, high_ext;
	logic                        at_low, at_high;
	logic [W-1:0]                span, mag_off, gain_span;
	logic                        gain_down;
	logic [ags_pkg::MUL_W-1:0]   alpha_ext, alpha_sat, alpha_rest;
	logic [ags_pkg::ACC_W-1:0]   acc_sum;
	logic [W-1:0]                gain_new;
	logic [W-1:0]                mag_sat;
	logic                        out_free;
	logic                        sm_done;

	ags_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	ags_sub u_sub (
		.a   (sub_a),
		.b   (sub_b),
		.res (sub_r)
	);

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ags_pkg::ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_free  = !out_valid_q || out_ready;

	assign cnt_last_sq   = (cnt_q == ags_pkg::CNT_W'(3));
	assign cnt_last_root = (cnt_q == ags_pkg::CNT_W'(ags_pkg::MAG_W - 1));
	assign cnt_last_div  = (cnt_q == ags_pkg::CNT_W'(W - 1));

	// Root step: bring down two radicand bits, try subtracting 4*root+1
	assign root_trial_a = {rem_q[ags_pkg::REM_W-3:0], rad_q[ags_pkg::SUM_W-1 -: 2]};
	assign root_trial_b = {1'b0, root_q, 2'b01};
	// Divide step: bring down one dividend bit, try subtracting the span
	assign div_trial_a  = {nd_q[2*W-1:W], nd_q[W-1]};

	always_comb begin
		if (state_q == ags_pkg::ST_DIV) begin
			sub_a = ags_pkg::SUB_W'(div_trial_a);
			sub_b = ags_pkg::SUB_W'(span);
		end else begin
			sub_a = ags_pkg::SUB_W'(root_trial_a);
			sub_b = ags_pkg::SUB_W'(root_trial_b);
		end
	end

	// Threshold compare and interpolation operands
	assign mag_ext   = ags_pkg::CMP_W'(root_q);
	assign low_ext   = ags_pkg::CMP_W'(low_rate_q);
	assign high_ext  = ags_pkg::CMP_W'(high_rate_q);
	assign at_low    = (mag_ext <= low_ext);
	assign at_high   = (mag_ext >= high_ext);
	assign span      = high_rate_q - low_rate_q;
	assign mag_off   = W'(mag_ext - low_ext);
	assign gain_down = (max_gain_q < min_gain_q);
	assign gain_span = gain_down ? (min_gain_q - max_gain_q) : (max_gain_q - min_gain_q);

	// Smoothing weight, saturated to one
	assign alpha_ext  = ags_pkg::MUL_W'(launched_q ? alpha_launched_q : alpha_idle_q);
	assign alpha_sat  = (alpha_ext > ags_pkg::GAIN_ONE) ? ags_pkg::GAIN_ONE : alpha_ext;
	assign alpha_rest = ags_pkg::GAIN_ONE - alpha_sat;

	assign acc_sum  = acc_q + ags_pkg::ACC_W'(mul_p);
	assign gain_new = acc_sum[ags_pkg::GAIN_FRAC_BITS +: W];

	// Magnitude clipped to the output field
	always_comb begin
		if (ags_pkg::MAG_W > W && (ags_pkg::CMP_W'(root_q) >> W) != '0) begin
			mag_sat = '1;
		end else begin
			mag_sat = W'(root_q);
		end
	end

	// Multiplier operand selection by step
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ags_pkg::ST_SQ: begin
				case (cnt_q[1:0])
					2'd0: begin
						mul_a = ags_pkg::MUL_W'(abs_x_q);
						mul_b = ags_pkg::MUL_W'(abs_x_q);
					end
					2'd1: begin
						mul_a = ags_pkg::MUL_W'(abs_y_q);
						mul_b = ags_pkg::MUL_W'(abs_y_q);
					end
					default: begin
						mul_a = ags_pkg::MUL_W'(abs_z_q);
						mul_b = ags_pkg::MUL_W'(abs_z_q);
					end
				endcase
			end
			ags_pkg::ST_CMP: begin
				mul_a = ags_pkg::MUL_W'(mag_off);
				mul_b = ags_pkg::MUL_W'(gain_span);
			end
			ags_pkg::ST_SM0: begin
				mul_a = ags_pkg::MUL_W'(gain_q);
				mul_b = alpha_rest;
			end
			ags_pkg::ST_SM1, ags_pkg::ST_SM2: begin
				mul_a = ags_pkg::MUL_W'(tgt_q);
				mul_b = alpha_sat;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign sm_done = (state_q == ags_pkg::ST_SM2) && out_free;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ags_pkg::ST_IDLE: begin
				if (in_valid) state_d = ags_pkg::ST_SQ;
			end
			ags_pkg::ST_SQ: begin
				if (cnt_last_sq) state_d = ags_pkg::ST_SQRT;
			end
			ags_pkg::ST_SQRT: begin
				if (cnt_last_root) state_d = ags_pkg::ST_CMP;
			end
			ags_pkg::ST_CMP: begin
				if (at_low || at_high) state_d = ags_pkg::ST_SM0;
				else                   state_d = ags_pkg::ST_DMUL;
			end
			ags_pkg::ST_DMUL: state_d = ags_pkg::ST_DIV;
			ags_pkg::ST_DIV: begin
				if (cnt_last_div) state_d = ags_pkg::ST_TGT;
			end
			ags_pkg::ST_TGT: state_d = ags_pkg::ST_SM0;
			ags_pkg::ST_SM0: state_d = ags_pkg::ST_SM1;
			ags_pkg::ST_SM1: state_d = ags_pkg::ST_SM2;
			ags_pkg::ST_SM2: begin
				if (out_free) state_d = ags_pkg::ST_IDLE;
			end
			default: state_d = ags_pkg::ST_IDLE;
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ags_pkg::ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q != state_d) cnt_q <= '0;
			else                    cnt_q <= cnt_q + 1'b1;
			if (sm_done)        out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// Configuration and stored gain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_rate_q       <= ags_pkg::RST_LOW_RATE;
			high_rate_q      <= ags_pkg::RST_HIGH_RATE;
			min_gain_q       <= ags_pkg::RST_MIN_GAIN;
			max_gain_q       <= ags_pkg::RST_MAX_GAIN;
			alpha_launched_q <= ags_pkg::RST_ALPHA_LAUNCHED;
			alpha_idle_q     <= ags_pkg::RST_ALPHA_IDLE;
			gain_q           <= ags_pkg::RST_GAIN;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					ags_pkg::REG_LOW_RATE:       low_rate_q       <= cfg_data;
					ags_pkg::REG_HIGH_RATE:      high_rate_q      <= cfg_data;
					ags_pkg::REG_MIN_GAIN:       min_gain_q       <= cfg_data;
					ags_pkg::REG_MAX_GAIN:       max_gain_q       <= cfg_data;
					ags_pkg::REG_ALPHA_LAUNCHED: alpha_launched_q <= cfg_data;
					ags_pkg::REG_ALPHA_IDLE:     alpha_idle_q     <= cfg_data;
					default: ;
				endcase
			end
			if (sm_done) gain_q <= gain_new;
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ags_pkg::ST_IDLE: begin
				abs_x_q    <= in_data.rate_x[RW-1] ? RW'(-in_data.rate_x) : RW'(in_data.rate_x);
				abs_y_q    <= in_data.rate_y[RW-1] ? RW'(-in_data.rate_y) : RW'(in_data.rate_y);
				abs_z_q    <= in_data.rate_z[RW-1] ? RW'(-in_data.rate_z) : RW'(in_data.rate_z);
				launched_q <= in_data.launched;
				rad_q      <= '0;
			end
			ags_pkg::ST_SQ: begin
				// products land in the cycle after issue, from the multiplier's output register
				if (cnt_q != '0) rad_q <= rad_q + mul_p[ags_pkg::SUM_W-1:0];
				rem_q  <= '0;
				root_q <= '0;
			end
			ags_pkg::ST_SQRT: begin
				rem_q  <= sub_r.ge ? sub_r.diff[ags_pkg::REM_W-1:0] : root_trial_a;
				root_q <= {root_q[ags_pkg::MAG_W-2:0], sub_r.ge};
				rad_q  <= rad_q << 2;
			end
			ags_pkg::ST_CMP: begin
				tgt_q <= at_low ? min_gain_q : max_gain_q;
			end
			ags_pkg::ST_DMUL: begin
				nd_q <= mul_p[2*W-1:0];
			end
			ags_pkg::ST_DIV: begin
				if (sub_r.ge) nd_q <= {sub_r.diff[W-1:0], nd_q[W-2:0], 1'b1};
				else          nd_q <= {div_trial_a[W-1:0], nd_q[W-2:0], 1'b0};
			end
			ags_pkg::ST_TGT: begin
				tgt_q <= gain_down ? (min_gain_q - nd_q[W-1:0]) : (min_gain_q + nd_q[W-1:0]);
			end
			ags_pkg::ST_SM1: begin
				acc_q <= ags_pkg::ACC_W'(mul_p);
			end
			ags_pkg::ST_SM2: begin
				if (out_free) begin
					out_q.gain           <= gain_new;
					out_q.rate_magnitude <= mag_sat;
				end
			end
			default: ;
		endcase
	end

endmodule

FILE: hw/rtl/ags_sub.sv
// ----------------------------------------------------------------------------
// ags_sub: shared trial subtractor
// Difference and greater-or-equal flag, used by the root and divide steps.
// ----------------------------------------------------------------------------
module ags_sub (
	input  logic [ags_pkg::SUB_W-1:0] a,
	input  logic [ags_pkg::SUB_W-1:0] b,
	output ags_pkg::sub_res_t         res
);

	logic [ags_pkg::SUB_W:0] wide;

	assign wide      = {1'b0, a} - {1'b0, b};
	assign res.ge    = ~wide[ags_pkg::SUB_W];
	assign res.diff  = wide[ags_pkg::SUB_W-1:0];

endmodule

FILE: hw/rtl/ags_mul.sv
// ----------------------------------------------------------------------------
// ags_mul: shared registered multiplier
// Unsigned product with an output register; one product per cycle.
// ----------------------------------------------------------------------------
module ags_mul (
	input  logic                      clk,
	input  logic [ags_pkg::MUL_W-1:0] a,
	input  logic [ags_pkg::MUL_W-1:0] b,
	output logic [ags_pkg::PRD_W-1:0] p
);

	logic [ags_pkg::PRD_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= ags_pkg::PRD_W'(a) * ags_pkg::PRD_W'(b);
	end

	assign p = p_q;

endmodule

FILE: hw/rtl/ags_checker.sv
// ----------------------------------------------------------------------------
// ags_checker: port-level checks for the adaptive gain scheduler
// Busy window after a transaction, output hold and configuration readiness.
// ----------------------------------------------------------------------------
module ags_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input ags_pkg::out_item_t out_data,
	input logic               cfg_ready
);

	// the sequencer stays busy after taking a sample
	a_busy_next: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken again right after a transaction");

	a_busy_long: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> ##2 !in_ready)
		else $error("sequencer idle too soon after a transaction");

	// no result may appear too soon after taking a sample while none was waiting
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !out_valid) |=> ##1 !out_valid)
		else $error("result appeared too soon");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
		else $error("stalled result changed or dropped");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

endmodule

bind adaptive_gain_scheduler ags_checker u_ags_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data),
	.cfg_ready (cfg_ready)
);

FILE: tb/sv/tb_adaptive_gain_scheduler.sv
// ----------------------------------------------------------------------------
// tb_adaptive_gain_scheduler: self-checking bench for the gain scheduler
// Feeds gyro transactions and register writes into the scheduler, predicts
// each result with a behavioural model kept alongside, and compares the
// outputs field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_adaptive_gain_scheduler;
	timeunit 1ns;
	timeprecision 1ps;

	import ags_pkg::*;

	// Register indexes past alpha_idle; the block must ignore writes to them
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = CFG_IDX_W'(6);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = CFG_IDX_W'(7);

	localparam int IDLE_PCT      = 14;   // chance of a bubble per cycle, each side
	localparam int HOLD_CYCLES   = 250;  // one long back-pressure stretch
	localparam int HOLD_AFTER    = 400;  // ... started once this many results are in
	localparam int PHASE_ITEMS   = 130;
	localparam int RANDOM_PHASES = 8;
	localparam int TAIL_CYCLES   = 60;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	in_item_t             in_data   = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_item_t            out_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [REG_W-1:0]     cfg_data  = '0;

	// Register copies, updated on each accepted write transaction
	logic [REG_W-1:0] low_rate_q       = RST_LOW_RATE;
	logic [REG_W-1:0] high_rate_q      = RST_HIGH_RATE;
	logic [REG_W-1:0] min_gain_q       = RST_MIN_GAIN;
	logic [REG_W-1:0] max_gain_q       = RST_MAX_GAIN;
	logic [REG_W-1:0] alpha_launched_q = RST_ALPHA_LAUNCHED;
	logic [REG_W-1:0] alpha_idle_q     = RST_ALPHA_IDLE;
	// Smoothed gain as the block should hold it after the last accepted sample
	logic [REG_W-1:0] gain_track       = RST_GAIN;

	in_item_t    pending_samples[$];
	out_item_t   expected_results[$];
	int unsigned samples_loaded = 0;
	int unsigned samples_taken  = 0;
	int unsigned results_seen   = 0;
	int unsigned mismatches     = 0;
	bit          calm           = 1'b0;  // no bubbles on either side
	int unsigned hold_left      = 0;
	bit          hold_done      = 1'b0;

	adaptive_gain_scheduler dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Prediction: magnitude, target gain and one smoothing step
	// ------------------------------------------------------------------------
	function automatic out_item_t predict_schedule(input in_item_t s,
			input logic [REG_W-1:0] prev);
		longint    rx, ry, rz, sumsq, mag, trial;
		longint    lo, hi, gmin, gmax, target, weight, one, acc, old;
		out_item_t r;
		one   = longint'(1) << GAIN_FRAC_BITS;
		rx    = longint'($signed(s.rate_x));
		ry    = longint'($signed(s.rate_y));
		rz    = longint'($signed(s.rate_z));
		sumsq = rx * rx + ry * ry + rz * rz;
		// Floor square root, one bit at a time from the top
		mag = 0;
		for (int b = MAG_W; b >= 0; b--) begin
			trial = mag | (longint'(1) << b);
			if (trial * trial <= sumsq)
				mag = trial;
		end
		// Widen everything to signed 64 bit first so the interpolation stays signed
		lo   = low_rate_q;
		hi   = high_rate_q;
		gmin = min_gain_q;
		gmax = max_gain_q;
		// With crossed thresholds one of the first two tests always catches, so no division
		if (mag <= lo)
			target = gmin;
		else if (mag >= hi)
			target = gmax;
		else
			target = gmin + ((mag - lo) * (gmax - gmin)) / (hi - lo);
		weight = s.launched ? longint'(alpha_launched_q) : longint'(alpha_idle_q);
		if (weight > one)
			weight = one;
		old = prev;
		acc = old * (one - weight) + target * weight;
		r.gain           = REG_W'(acc >>> GAIN_FRAC_BITS);
		r.rate_magnitude = (mag > 65535) ? '1 : REG_W'(mag);
		return r;
	endfunction

	task automatic report_failure(input string what);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t ns mismatch: %s", $realtime, what);
	endtask

	// ------------------------------------------------------------------------
	// Monitor: everything is sampled at the rising edge
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_LOW_RATE:       low_rate_q       = cfg_data;
					REG_HIGH_RATE:      high_rate_q      = cfg_data;
					REG_MIN_GAIN:       min_gain_q       = cfg_data;
					REG_MAX_GAIN:       max_gain_q       = cfg_data;
					REG_ALPHA_LAUNCHED: alpha_launched_q = cfg_data;
					REG_ALPHA_IDLE:     alpha_idle_q     = cfg_data;
					default: ;
				endcase
			end
			// Results first: one leaving now can never belong to a sample taken now
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					report_failure($sformatf("result with nothing pending: gain %0d magnitude %0d",
						out_data.gain, out_data.rate_magnitude));
				end else begin
					want = expected_results.pop_front();
					if (out_data.gain !== want.gain)
						report_failure($sformatf("result %0d gain: expected %0d, got %0d",
							results_seen, want.gain, out_data.gain));
					if (out_data.rate_magnitude !== want.rate_magnitude)
						report_failure($sformatf("result %0d magnitude: expected %0d, got %0d",
							results_seen, want.rate_magnitude, out_data.rate_magnitude));
				end
			end
			if (in_valid && in_ready) begin
				want       = predict_schedule(in_data, gain_track);
				gain_track = want.gain;
				expected_results.push_back(want);
				samples_taken++;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Sample driver: loads a new transaction once the last one has gone
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n && samples_taken == samples_loaded) begin
			if (pending_samples.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
				in_data  <= pending_samples.pop_front();
				in_valid <= 1'b1;
				samples_loaded++;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result receiver: random bubbles plus one long hold so the output
	// register and the last smoothing step both fill and in_ready drops
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n) begin
			if (!hold_done && results_seen >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= calm || $urandom_range(99) >= IDLE_PCT;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	task automatic queue_sample(input int x, input int y, input int z, input bit launch);
		in_item_t s;
		s.rate_x   = RATE_WIDTH'(x);
		s.rate_y   = RATE_WIDTH'(y);
		s.rate_z   = RATE_WIDTH'(z);
		s.launched = launch;
		pending_samples.push_back(s);
	endtask

	function automatic int span_rate(input int bound);
		return int'($urandom_range(2 * bound)) - bound;
	endfunction

	function automatic logic [REG_W-1:0] pick_weight();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			default: return REG_W'($urandom);
		endcase
	endfunction

	// Mostly rates scaled to the current thresholds so the interpolation is
	// exercised, with full-range noise, corner values and exact threshold hits
	task automatic queue_random_sample();
		int corner_vals[5] = '{-32768, -1, 0, 1, 32767};
		int bound, thr;
		bit launch;
		launch = 1'($urandom_range(1));
		bound  = (low_rate_q > high_rate_q) ? int'(low_rate_q) : int'(high_rate_q);
		if (bound > 32767)
			bound = 32767;
		if (bound < 64)
			bound = 64;
		case ($urandom_range(9))
			0, 1: queue_sample(int'($urandom), int'($urandom), int'($urandom), launch);
			2: begin
				thr = $urandom_range(1) ? int'(low_rate_q) : int'(high_rate_q);
				if (thr > 32766)
					thr = 32766;
				thr = thr + int'($urandom_range(2)) - 1;
				if ($urandom_range(1))
					thr = -thr;
				queue_sample(thr, 0, 0, launch);
			end
			3: queue_sample(corner_vals[$urandom_range(4)], corner_vals[$urandom_range(4)],
				corner_vals[$urandom_range(4)], launch);
			default: queue_sample(span_rate(bound), span_rate(bound), span_rate(bound), launch);
		endcase
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// All six registers plus one write to a spare index that must change nothing
	task automatic apply_settings(input logic [REG_W-1:0] lo, input logic [REG_W-1:0] hi,
			input logic [REG_W-1:0] gmin, input logic [REG_W-1:0] gmax,
			input logic [REG_W-1:0] a_run, input logic [REG_W-1:0] a_rest);
		write_reg(REG_LOW_RATE, lo);
		write_reg(REG_HIGH_RATE, hi);
		write_reg(REG_MIN_GAIN, gmin);
		write_reg(REG_MAX_GAIN, gmax);
		write_reg(REG_ALPHA_LAUNCHED, a_run);
		write_reg(REG_ALPHA_IDLE, a_rest);
		write_reg($urandom_range(1) ? REG_SPARE_6 : REG_SPARE_7, REG_W'($urandom));
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Sender holds off until every sample is in and every result is out
	task automatic wait_idle();
		do @(negedge clk);
		while (pending_samples.size() != 0 || samples_taken != samples_loaded
			|| expected_results.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin
		logic [REG_W-1:0] lo, hi;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: zero, full-scale corners, alternating bits, both sides
		// of each threshold, and values inside the interpolation band
		queue_sample(0, 0, 0, 0);
		queue_sample(-32768, -32768, -32768, 1);
		queue_sample(32767, 32767, 32767, 0);
		queue_sample(21845, -21846, -1, 1);
		queue_sample(320, 0, 0, 1);
		queue_sample(0, -321, 0, 0);
		queue_sample(0, 0, 1599, 1);
		queue_sample(1600, 0, 0, 0);
		queue_sample(-1601, 0, 0, 1);
		queue_sample(200, 200, 200, 0);
		queue_sample(1000, -500, 700, 1);
		queue_sample(-12345, 23456, -345, 0);

		// Thresholds crossed; full weight when launched, none when idle
		wait_idle();
		apply_settings(16'd1600, 16'd320, 16'd19661, 16'd52429, 16'hFFFF, 16'h0000);
		queue_sample(0, 0, 0, 1);
		queue_sample(1600, 0, 0, 0);
		queue_sample(0, 1601, 0, 1);
		queue_sample(0, 0, -5000, 1);

		// Gains reversed: the interpolation runs downwards
		wait_idle();
		apply_settings(16'd100, 16'd5000, 16'd60000, 16'd1000, 16'd32768, 16'hFFFF);
		queue_sample(2500, 0, 0, 1);
		queue_sample(1234, -2345, 987, 0);
		queue_sample(0, 4999, 0, 1);

		// Equal thresholds
		wait_idle();
		apply_settings(16'd1000, 16'd1000, 16'd0, 16'hFFFF, 16'hFFFF, 16'd1);
		queue_sample(999, 0, 0, 1);
		queue_sample(1000, 0, 0, 1);
		queue_sample(0, 0, 1001, 1);

		// Widest band and extreme gains
		wait_idle();
		apply_settings(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd1, 16'hFFFE);
		queue_sample(0, 0, 0, 1);
		queue_sample(-32768, -32768, -32768, 1);
		queue_sample(30000, -20000, 10000, 0);

		// Random phases; one of them runs with no bubbles at all
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			wait_idle();
			if ($urandom_range(3) == 0) begin
				lo = REG_W'($urandom);
				hi = REG_W'($urandom);
			end else begin
				lo = REG_W'($urandom_range(3000));
				hi = lo + REG_W'($urandom_range(25000, 1));
			end
			apply_settings(lo, hi, REG_W'($urandom), REG_W'($urandom),
				pick_weight(), pick_weight());
			calm <= (p == 2);
			repeat (PHASE_ITEMS) queue_random_sample();
		end

		wait_idle();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Watchdog, several times the slowest legal run
	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
